// ===== hdl/lisps_pkg.sv =====
// shared types and constants for the patience-sort lis length core
// no dependencies
package lisps_pkg;

    // width of the value field on the item port
    localparam int unsigned PORT_VALUE_BITS = 32;

    // link handed from one tail cell to the next
    typedef struct packed {
        logic below;   // this cell holds a tail and that tail is below the key
    } lisps_link_t;

endpackage

// ===== hdl/lisps_cell.sv =====
// one tail cell of the sorted tail chain
// depends on lisps_pkg
module lisps_cell #(
    parameter int unsigned VALUE_BITS = 32,
    parameter int unsigned CNT_BITS   = 7,
    parameter int unsigned INDEX      = 0
) (
    input  logic                       clk,
    input  logic                       load,
    input  logic [VALUE_BITS-1:0]      key,
    input  logic [CNT_BITS-1:0]        count_eff,
    input  lisps_pkg::lisps_link_t     link_prev,
    output lisps_pkg::lisps_link_t     link_next,
    output logic                       append
);
    import lisps_pkg::*;

    localparam logic [CNT_BITS-1:0] IDX = CNT_BITS'(INDEX);

    logic [VALUE_BITS-1:0] tail_reg;
    logic                  in_use;
    logic                  below;
    logic                  take;

    assign in_use          = IDX < count_eff;
    assign below           = in_use && (tail_reg < key);
    assign link_next.below = below;

    // first cell at or above the key, or the first free cell after all smaller tails
    assign take   = link_prev.below && !below;
    assign append = take && !in_use;

    always_ff @(posedge clk)
    begin
        if (load && take)
        begin
            tail_reg <= key;
        end
    end

endmodule

// ===== hdl/lis_length_patience_sort_core.sv =====
// the result is registered and valid in the cycle after the item transfer; throughput: one item per cycle
// whenever the result register is free or drained in the same cycle
// the position search is a chain of DEPTH tail cells, each comparing its own tail
// with the broadcast key and passing a below flag to its right neighbor
// reset (rst_n low, asynchronous) empties the tail store and the result register
module lis_length_patience_sort_core #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // item channel
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic [lisps_pkg::PORT_VALUE_BITS-1:0] value,
    input  logic                                  start_req,
    // result channel
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic [$clog2(DEPTH + 1)-1:0]          length,
    output logic                                  dropped
);
    import lisps_pkg::*;

    localparam int unsigned         LEN_BITS = $clog2(DEPTH + 1);
    localparam logic [LEN_BITS-1:0] FULL     = LEN_BITS'(DEPTH);

    // tail count and result register
    logic [LEN_BITS-1:0] count_reg;
    logic [LEN_BITS-1:0] count_next;
    logic                valid_reg;
    logic [LEN_BITS-1:0] length_reg;
    logic                dropped_reg;

    logic                accept;
    logic [LEN_BITS-1:0] count_eff;
    logic [VALUE_BITS-1:0] ext;
    logic [VALUE_BITS-1:0] key;
    logic                grow;
    logic                drop;

    lisps_link_t         links [DEPTH+1];
    logic [DEPTH-1:0]    appends;

    // result register frees when drained, so a new item may enter in the same cycle
    assign item_stall = valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    // a start request empties the store before the value is placed
    assign count_eff = start_req ? '0 : count_reg;

    // take the low VALUE_BITS bits, or sign-extend when wider than the port
    generate
        if (VALUE_BITS <= PORT_VALUE_BITS)
        begin : g_narrow
            assign ext = value[VALUE_BITS-1:0];
        end
        else
        begin : g_wide
            assign ext = {{(VALUE_BITS - PORT_VALUE_BITS){value[PORT_VALUE_BITS-1]}}, value};
        end
    endgenerate

    // flipping the sign bit turns signed order into unsigned order
    assign key = ext ^ {1'b1, {(VALUE_BITS-1){1'b0}}};

    // head of the chain: everything to the left counts as below the key
    assign links[0].below = 1'b1;

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            lisps_cell #(
                .VALUE_BITS (VALUE_BITS),
                .CNT_BITS   (LEN_BITS),
                .INDEX      (i)
            ) u_cell (
                .clk       (clk),
                .load      (accept),
                .key       (key),
                .count_eff (count_eff),
                .link_prev (links[i]),
                .link_next (links[i+1]),
                .append    (appends[i])
            );
        end
    endgenerate

    // last cell full and below the key: every tail is smaller, no room to append
    assign drop       = links[DEPTH].below;
    assign grow       = |appends;
    assign count_next = grow ? count_eff + LEN_BITS'(1) : count_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
                valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded on every item transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            length_reg  <= count_next;
            dropped_reg <= drop;
        end
    end

    assign result_valid = valid_reg;
    assign length       = length_reg;
    assign dropped      = dropped_reg;

    // store never holds more than DEPTH tails
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("tail count above depth");

    // a refused append only happens on a full store
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && dropped_reg) |-> (length_reg == FULL))
        else $error("drop reported with store not full");

    // every item transfer yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> valid_reg)
        else $error("missing result after item transfer");

    // a new sequence holds exactly one tail after its first item
    a_start_one: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && start_req) |=> (count_reg == LEN_BITS'(1)))
        else $error("start did not restart the tail store");

endmodule
